/* rtl/core/depth_pixel_backprojection_defines.svh */
// Assertion macros shared by the files that check their own logic.
// Each macro expects clk and arst_n in scope.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DEPB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define DEPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/depb_pkg.sv */
package depb_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 24;

	localparam logic [REG_IDX_W-1:0] REG_INV_SCALE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INV_FX    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INV_FY    = 3'd4;

	localparam logic [23:0] INV_SCALE_RST = 24'd16777;
	localparam logic [15:0] CENTER_X_RST  = 16'd5120;
	localparam logic [15:0] CENTER_Y_RST  = 16'd3840;
	localparam logic [23:0] INV_FX_RST    = 24'd31957;
	localparam logic [23:0] INV_FY_RST    = 24'd31957;

	typedef struct packed {
		logic [23:0] inv_scale;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] inv_fx;
		logic [23:0] inv_fy;
	} depb_cfg_t;

	// Load enables of the stages behind stage 1.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} depb_adv_t;

endpackage

/* rtl/core/depb_cfg_regs.sv */
module depb_cfg_regs
	import depb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	output depb_cfg_t             cfg
);

	depb_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_scale <= INV_SCALE_RST;
			cfg_q.center_x  <= CENTER_X_RST;
			cfg_q.center_y  <= CENTER_Y_RST;
			cfg_q.inv_fx    <= INV_FX_RST;
			cfg_q.inv_fy    <= INV_FY_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INV_SCALE: cfg_q.inv_scale <= wr_data;
				REG_CENTER_X:  cfg_q.center_x  <= wr_data[15:0];
				REG_CENTER_Y:  cfg_q.center_y  <= wr_data[15:0];
				REG_INV_FX:    cfg_q.inv_fx    <= wr_data;
				REG_INV_FY:    cfg_q.inv_fy    <= wr_data;
				default:       ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/depb_axis.sv */
module depb_axis
	import depb_pkg::*;
(
	input  logic               clk,
	input  depb_adv_t          adv,
	input  logic signed [16:0] ofs_s1,
	input  logic [31:0]        z_s1,
	input  logic [23:0]        inv,
	output logic [39:0]        pos_s4
);

	logic signed [49:0] prod_sz;
	logic signed [48:0] p_s2;
	logic [47:0]        lo_prod;
	logic signed [49:0] hi_prod;
	logic [47:0]        lo_s3;
	logic [48:0]        hi_s3;
	logic [72:0]        sum;
	logic [44:0]        quo;
	logic [39:0]        sat;

	assign prod_sz = ofs_s1 * $signed({1'b0, z_s1});

	// Split the offset-times-z product so each partial product stays near 24x24.
	assign lo_prod = p_s2[23:0] * inv;
	assign hi_prod = $signed(p_s2[48:24]) * $signed({1'b0, inv});

	// Floor division by 2^28 is the arithmetic shift of the full product.
	assign sum = {hi_s3, 24'd0} + {25'd0, lo_s3};
	assign quo = sum[72:28];

	always_comb begin
		if (quo[44:39] == 6'b000000 || quo[44:39] == 6'b111111) begin
			sat = quo[39:0];
		end else if (quo[44]) begin
			sat = {1'b1, 39'd0};
		end else begin
			sat = {1'b0, {39{1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p_s2 <= prod_sz[48:0];
		end
		if (adv.s3) begin
			lo_s3 <= lo_prod;
			hi_s3 <= hi_prod[48:0];
		end
		if (adv.s4) begin
			pos_s4 <= sat;
		end
	end

endmodule

/* rtl/core/depth_pixel_backprojection.sv */
// Pinhole back-projection of RGB-D pixels into 3-D points.
// Input channel: in_valid/in_ready with depth, pixel_col, pixel_row, blue, green,
// red and last_pixel. Output channel: out_valid/out_ready with point_valid,
// pos_x, pos_y (signed Q24.16, saturated), pos_z (Q16.16), colour and out_last.
// Registers are written through wr_en/wr_index/wr_data; the user must write them only
// while no pixel is in flight, which the block itself does not enforce; index 0
// inv_scale, 1 center_x, 2 center_y, 3 inv_fx, 4 inv_fy. Throughput: one pixel per
// cycle while out_ready keeps the output moving, set by the four-stage multiplier
// pipeline (depth scale, offset times z, split reciprocal products, sum and saturate).
// A zero depth, or a pixel outside MAX_WIDTH x MAX_HEIGHT, comes out with
// point_valid low and zero coordinates; colour and out_last still pass through.
// When out_ready is low the pipeline keeps filling its empty stages and holds
// every request; in_ready drops only once all four stages are occupied.
// Reset empties the pipeline and returns the registers to their default values.
`include "depth_pixel_backprojection_defines.svh"

module depth_pixel_backprojection
	import depb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           depth,
	input  logic [11:0]           pixel_col,
	input  logic [11:0]           pixel_row,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic                  last_pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  point_valid,
	output logic signed [39:0]    pos_x,
	output logic signed [39:0]    pos_y,
	output logic [31:0]           pos_z,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_green,
	output logic [7:0]            out_red,
	output logic                  out_last
);

	typedef struct packed {
		logic       pv;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic       last;
	} depb_side_t;

	depb_cfg_t  cfg;
	depb_adv_t  adv;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	depb_side_t side_in;
	depb_side_t side_s1, side_s2, side_s3, side_s4;

	logic               in_frame;
	logic               pv_in;
	logic [39:0]        zprod;
	logic [31:0]        z_s1, z_s2, z_s3, z_s4;
	logic signed [16:0] ofs_x, ofs_y;
	logic signed [16:0] ofs_x_s1, ofs_y_s1;
	logic [39:0]        x_s4, y_s4;

	depb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// A stage loads when it is empty or its contents move on.
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign adv.s2 = rdy2;
	assign adv.s3 = rdy3;
	assign adv.s4 = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign in_frame = ({5'd0, pixel_col} < 17'(MAX_WIDTH))
		&& ({5'd0, pixel_row} < 17'(MAX_HEIGHT));
	assign pv_in  = (depth != 16'd0) && in_frame;

	assign side_in = '{pv: pv_in, b: blue, g: green, r: red, last: last_pixel};

	assign zprod = depth * cfg.inv_scale;
	assign ofs_x = $signed({1'b0, pixel_col, 4'd0}) - $signed({1'b0, cfg.center_x});
	assign ofs_y = $signed({1'b0, pixel_row, 4'd0}) - $signed({1'b0, cfg.center_y});

	// Stage 1 scales depth and zeros z on a dropped pixel so x and y come out zero; stages 2 to 4 carry side data and z.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1  <= side_in;
			z_s1     <= pv_in ? zprod[39:8] : 32'd0;
			ofs_x_s1 <= ofs_x;
			ofs_y_s1 <= ofs_y;
		end
		if (rdy2) begin
			side_s2 <= side_s1;
			z_s2    <= z_s1;
		end
		if (rdy3) begin
			side_s3 <= side_s2;
			z_s3    <= z_s2;
		end
		if (rdy4) begin
			side_s4 <= side_s3;
			z_s4    <= z_s3;
		end
	end

	depb_axis u_axis_x (
		.clk    (clk),
		.adv    (adv),
		.ofs_s1 (ofs_x_s1),
		.z_s1   (z_s1),
		.inv    (cfg.inv_fx),
		.pos_s4 (x_s4)
	);

	depb_axis u_axis_y (
		.clk    (clk),
		.adv    (adv),
		.ofs_s1 (ofs_y_s1),
		.z_s1   (z_s1),
		.inv    (cfg.inv_fy),
		.pos_s4 (y_s4)
	);

	assign out_valid   = v_s4;
	assign point_valid = side_s4.pv;
	assign pos_x       = $signed(x_s4);
	assign pos_y       = $signed(y_s4);
	assign pos_z       = z_s4;
	assign out_blue    = side_s4.b;
	assign out_green   = side_s4.g;
	assign out_red     = side_s4.r;
	assign out_last    = side_s4.last;

	`DEPB_ASSERT_NOW(a_ready_chain, out_ready, in_ready, "in_ready low while output drains")
	`DEPB_ASSERT_NOW(a_full_stall, v_s1 && v_s2 && v_s3 && v_s4 && !out_ready, !in_ready,
		"request taken into a full stalled pipeline")
	`DEPB_ASSERT_NOW(a_drop_zero, out_valid && !point_valid,
		pos_x == 40'sd0 && pos_y == 40'sd0 && pos_z == 32'd0,
		"dropped pixel carries nonzero coordinates")
	`DEPB_ASSERT_NEXT(a_hold_stall, v_s4 && !out_ready,
		v_s4 && $stable(z_s4) && $stable(x_s4) && $stable(side_s4),
		"stalled result changed in the output stage")

endmodule
